// ----- rtl/tip_pkg.sv -----
// shared types and constants for the table interpolator
package tip_pkg;

  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = 7;
  localparam int X_W        = 12;
  localparam int Y_W        = 16;
  localparam int NUM_W      = 64;
  localparam int DEN_W      = 40;
  localparam int QCNT_W     = $clog2(NUM_W + 1);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  localparam logic [0:0] REG_MODE  = 1'b0;
  localparam logic [0:0] REG_COUNT = 1'b1;

  typedef struct packed {
    logic                  operation;
    logic [5:0]            point_index;
    logic [X_W-1:0]        point_x;
    logic signed [Y_W-1:0] point_y;
    logic [X_W-1:0]        query_x;
  } in_beat_t;

  typedef struct packed {
    logic signed [Y_W-1:0] value;
    logic                  saturated;
    logic                  error;
  } out_beat_t;

endpackage

// ----- rtl/tip_ram.sv -----
// generic single-port-write, single-read ram with registered read
module tip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/tip_queue.sv -----
// two-entry queue between front and back
module tip_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tip_pkg::in_beat_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output tip_pkg::in_beat_t pop_data
);
  import tip_pkg::*;

  in_beat_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ----- rtl/tip_back.sv -----
// table writes and evaluation engine: table scan, numerator build and iterative division
module tip_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      mode,
  input  logic [tip_pkg::CNT_W-1:0] count,
  input  logic                      q_empty,
  input  tip_pkg::in_beat_t         q_data,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output tip_pkg::out_beat_t        out_data
);
  import tip_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FIRST = 4'd1;
  localparam logic [3:0] S_LAST  = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_LOAD  = 4'd4;
  localparam logic [3:0] S_MUL1  = 4'd5;
  localparam logic [3:0] S_MUL2  = 4'd6;
  localparam logic [3:0] S_MUL3  = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;
  localparam logic [3:0] S_RD    = 4'd10;

  logic [3:0]             state_r;
  logic [IDX_W-1:0]       raddr;
  logic [X_W-1:0]         x_rd;
  logic signed [Y_W-1:0]  y_rd;
  logic                   we;
  logic [IDX_W:0]         n_r, lim_r, seg_r, ld_r;
  logic [X_W-1:0]         z_r;
  logic [X_W-1:0]         xs_r [3];
  logic signed [Y_W-1:0]  ys_r [3];
  logic signed [NUM_W-1:0] num_r, t0_r, t1_r, t2_r, rem_r, quo_r;
  logic signed [DEN_W-1:0] den_r;
  logic                   neg_r;
  logic [QCNT_W-1:0]      dcnt_r;
  out_beat_t              res_r;
  logic                   res_v_r;
  logic [IDX_W:0]         rd_idx_r;
  logic [3:0]             rd_ret_r;

  assign we = (state_r == S_IDLE) && !q_empty && !res_v_r
              && (q_data.operation == OP_WRITE);
  assign q_pop = (state_r == S_IDLE) && !q_empty && !res_v_r;
  assign raddr = rd_idx_r[IDX_W-1:0];

  tip_ram #(.WIDTH(X_W), .DEPTH(MAX_POINTS)) u_xram (
    .clk, .we, .waddr(q_data.point_index[IDX_W-1:0]), .wdata(q_data.point_x),
    .raddr, .rdata(x_rd));
  tip_ram #(.WIDTH(Y_W), .DEPTH(MAX_POINTS)) u_yram (
    .clk, .we, .waddr(q_data.point_index[IDX_W-1:0]), .wdata(q_data.point_y),
    .raddr, .rdata(y_rd));

  assign out_valid = res_v_r;
  assign out_data  = res_r;

  // signed differences of the zero-extended unsigned operands
  logic signed [13:0] dz0, dz1, dz2, d01, d02, d12;
  assign dz0 = $signed({2'b0, z_r}) - $signed({2'b0, xs_r[0]});
  assign dz1 = $signed({2'b0, z_r}) - $signed({2'b0, xs_r[1]});
  assign dz2 = $signed({2'b0, z_r}) - $signed({2'b0, xs_r[2]});
  assign d01 = $signed({2'b0, xs_r[0]}) - $signed({2'b0, xs_r[1]});
  assign d02 = $signed({2'b0, xs_r[0]}) - $signed({2'b0, xs_r[2]});
  assign d12 = $signed({2'b0, xs_r[1]}) - $signed({2'b0, xs_r[2]});

  logic [NUM_W-1:0] rem_sh, den_abs;
  assign rem_sh  = {rem_r[NUM_W-2:0], quo_r[NUM_W-1]};
  assign den_abs = {{(NUM_W-DEN_W){1'b0}}, den_r};

  logic signed [NUM_W-1:0] qsgn;
  assign qsgn = neg_r ? -quo_r : quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      res_v_r   <= 1'b0;
    end else begin
      if (res_v_r && out_ready) res_v_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_pop && q_data.operation == OP_EVAL) begin
            z_r <= q_data.query_x;
            n_r <= (count > CNT_W'(MAX_POINTS)) ? (IDX_W+1)'(MAX_POINTS)
                                                 : count[IDX_W:0];
            if (((count < CNT_W'(2)) && !mode) || ((count < CNT_W'(3)) && mode))
            begin
              res_r   <= '{value: '0, saturated: 1'b0, error: 1'b1};
              res_v_r <= 1'b1;
            end else begin
              rd_idx_r <= '0;
              state_r  <= S_RD;
              rd_ret_r <= S_FIRST;
            end
          end
        end
        S_RD: state_r <= rd_ret_r;  // read data lands next cycle
        S_FIRST: begin
          if (z_r < x_rd) begin
            res_r <= '{value: y_rd, saturated: 1'b0, error: 1'b0};
            res_v_r <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            rd_idx_r <= n_r - (IDX_W+1)'(1);
            rd_ret_r <= S_LAST;
            state_r  <= S_RD;
          end
        end
        S_LAST: begin
          if (z_r > x_rd) begin
            res_r <= '{value: y_rd, saturated: 1'b0, error: 1'b0};
            res_v_r <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            lim_r    <= n_r - (mode ? (IDX_W+1)'(3) : (IDX_W+1)'(2));
            seg_r    <= '0;
            rd_idx_r <= (IDX_W+1)'(1);
            rd_ret_r <= S_SCAN;
            state_r  <= S_RD;
          end
        end
        S_SCAN: begin
          // x_rd is x[seg+1]
          if (seg_r == lim_r || z_r < x_rd) begin
            ld_r     <= '0;
            rd_idx_r <= seg_r;
            rd_ret_r <= S_LOAD;
            state_r  <= S_RD;
          end else begin
            seg_r    <= seg_r + (IDX_W+1)'(1);
            rd_idx_r <= seg_r + (IDX_W+1)'(2);
            state_r  <= S_RD;
          end
        end
        S_LOAD: begin
          xs_r[ld_r[1:0]] <= x_rd;
          ys_r[ld_r[1:0]] <= y_rd;
          if (ld_r == (mode ? (IDX_W+1)'(2) : (IDX_W+1)'(1))) begin
            state_r <= S_MUL1;
          end else begin
            ld_r     <= ld_r + (IDX_W+1)'(1);
            rd_idx_r <= rd_idx_r + (IDX_W+1)'(1);
            state_r  <= S_RD;
          end
        end
        S_MUL1: begin
          if (!mode) begin
            den_r <= DEN_W'(-d01);
            t0_r  <= NUM_W'(ys_r[0] * -d01);
            t1_r  <= NUM_W'((ys_r[1] - ys_r[0]) * dz0);
          end else begin
            den_r <= DEN_W'(d01 * d02);
            t0_r  <= NUM_W'(dz1 * dz2);
            t1_r  <= NUM_W'(dz0 * dz2);
            t2_r  <= NUM_W'(dz0 * dz1);
          end
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          if (!mode) begin
            num_r   <= t0_r + t1_r;
            state_r <= S_MUL3;
          end else begin
            den_r <= DEN_W'(den_r * d12);
            t0_r  <= NUM_W'($signed(t0_r[27:0]) * d12);
            t1_r  <= NUM_W'($signed(t1_r[27:0]) * d02);
            t2_r  <= NUM_W'($signed(t2_r[27:0]) * d01);
            state_r <= S_MUL3;
          end
        end
        S_MUL3: begin
          if (mode) begin
            num_r <= NUM_W'(ys_r[0] * $signed(t0_r[41:0]))
                     - NUM_W'(ys_r[1] * $signed(t1_r[41:0]))
                     + NUM_W'(ys_r[2] * $signed(t2_r[41:0]));
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          // set up unsigned division of |num| by |den|
          if (den_r == '0) begin
            res_r   <= '{value: '0, saturated: 1'b0, error: 1'b1};
            res_v_r <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            neg_r  <= num_r[NUM_W-1] ^ den_r[DEN_W-1];
            quo_r  <= num_r[NUM_W-1] ? -num_r : num_r;
            den_r  <= den_r[DEN_W-1] ? -den_r : den_r;
            rem_r  <= '0;
            dcnt_r <= QCNT_W'(NUM_W);
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (dcnt_r == '0) begin
            res_v_r <= 1'b1;
            res_r.error <= 1'b0;
            if (qsgn > 64'sd32767) begin
              res_r.value <= 16'sh7fff; res_r.saturated <= 1'b1;
            end else if (qsgn < -64'sd32768) begin
              res_r.value <= 16'sh8000; res_r.saturated <= 1'b1;
            end else begin
              res_r.value <= qsgn[Y_W-1:0]; res_r.saturated <= 1'b0;
            end
            state_r <= S_IDLE;
          end else begin
            if (rem_sh >= den_abs) begin
              rem_r <= rem_sh - den_abs;
              quo_r <= {quo_r[NUM_W-2:0], 1'b1};
            end else begin
              rem_r <= rem_sh;
              quo_r <= {quo_r[NUM_W-2:0], 1'b0};
            end
            dcnt_r <= dcnt_r - QCNT_W'(1);
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/tip_front.sv -----
// front end: input handshake, config registers and push into the queue
module tip_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [6:0]                cfg_data,
  output logic                      mode,
  output logic [tip_pkg::CNT_W-1:0] count,
  output logic                      push,
  input  logic                      q_full
);
  import tip_pkg::*;

  logic                mode_r;
  logic [CNT_W-1:0]    count_r;

  assign in_ready  = rst_n && !q_full;
  assign push      = in_valid && in_ready;
  assign cfg_ready = rst_n;
  assign mode      = mode_r;
  assign count     = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      count_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODE:  mode_r  <= cfg_data[0];
        REG_COUNT: count_r <= cfg_data;
        default: ;
      endcase
    end
  end
endmodule

// ----- rtl/table_interpolator_linear_parabolic.sv -----
// top level of the linear / parabolic table interpolator
// write beats update the table straight from the queue; an evaluate beat runs two end reads,
// a scan over up to 63 segments, the point reads, three multiply steps and a 64-step
// restoring divider; the scan length sets how long an evaluate beat takes
// throughput: one beat at a time in the back end, next taken once the result beat is gone
// reset: synchronous active-low rst_n clears mode, count and control; table undefined
module table_interpolator_linear_parabolic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tip_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tip_pkg::out_beat_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_data
);
  import tip_pkg::*;

  logic             mode, push, q_full, q_empty, q_pop;
  logic [CNT_W-1:0] count;
  in_beat_t         q_data;

  // front: takes beats and config writes
  tip_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .cfg_valid, .cfg_ready,
    .cfg_index, .cfg_data, .mode, .count, .push, .q_full);

  // decoupling queue
  tip_queue u_queue (
    .clk, .rst_n, .push, .push_data(in_data), .full(q_full), .pop(q_pop),
    .empty(q_empty), .pop_data(q_data));

  // back: table memory and evaluation engine
  tip_back u_back (
    .clk, .rst_n, .mode, .count, .q_empty, .q_data, .q_pop,
    .out_valid, .out_ready, .out_data);
endmodule
